### design/etb_pkg.sv
// etb_pkg: shared constants and types for the elimination tree builder
// holds node index widths, ancestor store entry layout and sequencer states
// no dependencies
package etb_pkg;

  localparam int MaxNodes = 1024;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int AncW     = IdxW + 1;

  localparam logic [IdxW-1:0] LastNode = IdxW'(MaxNodes - 1);

  // input operation codes
  localparam logic OpEntry = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] node;
  } anc_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

### design/etb_ram.sv
// etb_ram: generic single write port, single read port ram
// read data registered, available in the cycle after the address; no package dependency
module etb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/elimination_tree_builder_core.sv
// elimination_tree_builder_core: builds the elimination tree of a sparse
// symmetric matrix from its nonzero entries; uses etb_pkg and etb_ram
//
// Usage:
//   Input beats on s_* carry one matrix entry or a clear command. s_tuser
//   is the operation (entry or clear), s_tdata holds row and column.
//   Entries come in nondecreasing column order; entries on or below the
//   diagonal are dropped. Each entry above the diagonal walks the ancestor
//   chain from its row node, path-compressing every node to the column.
//   When the walk reaches a node with no ancestor, one beat leaves on m_*
//   carrying (child, parent = column); otherwise the entry gives no beat.
//   Per entry: the beat is accepted, then each visited node takes a ram
//   read (ST_READ) and a write-back (ST_CHECK) through the single ancestor
//   ram, and a found pair is then loaded into the output register.
//   A clear command, and reset, run a clearing pass over all 1024 ancestor
//   entries, one per cycle; s_tready stays low during it.
//   The output register holds a pair until m_tready; a walk that finds a
//   new pair waits for it to drain, and s_tready is low while a walk runs.
module elimination_tree_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] row_index, [19:10] col_index, [23:20] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [9:0] child_node, [19:10] parent_node, [23:20] zero
);

  localparam int IdxW = etb_pkg::IdxW;

  etb_pkg::state_t state;
  logic [IdxW-1:0] node;
  logic [IdxW-1:0] col;
  logic [IdxW-1:0] clr_cnt;
  logic [IdxW-1:0] out_child;
  logic [IdxW-1:0] out_parent;

  logic [IdxW-1:0] in_row;
  logic [IdxW-1:0] in_col;
  logic            in_beat;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  etb_pkg::anc_t         ram_wdata;
  logic [etb_pkg::AncW-1:0] ram_rdata;
  etb_pkg::anc_t         anc;
  logic                  out_free;

  assign in_row   = s_tdata[IdxW-1:0];
  assign in_col   = s_tdata[2*IdxW-1:IdxW];
  assign s_tready = (state == etb_pkg::ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign anc      = etb_pkg::anc_t'(ram_rdata);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {4'b0, out_parent, out_child};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = '{valid: 1'b1, node: col};
    case (state)
      etb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '{valid: 1'b0, node: '0};
      end
      etb_pkg::ST_CHECK: begin
        // path compression: visited node now points at the column
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  etb_ram #(
    .Width(etb_pkg::AncW),
    .Depth(etb_pkg::MaxNodes)
  ) u_anc_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(node),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= etb_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == etb_pkg::ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        etb_pkg::ST_IDLE: begin
          if (in_beat) begin
            if (s_tuser == etb_pkg::OpClear) begin
              state   <= etb_pkg::ST_CLEAR;
              clr_cnt <= '0;
            end else if (in_row < in_col) begin
              state <= etb_pkg::ST_READ;
              node  <= in_row;
              col   <= in_col;
            end
          end
        end
        etb_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == etb_pkg::LastNode) begin
            state <= etb_pkg::ST_IDLE;
          end
        end
        etb_pkg::ST_READ: begin
          state <= etb_pkg::ST_CHECK;
        end
        etb_pkg::ST_CHECK: begin
          if (!anc.valid) begin
            state <= etb_pkg::ST_EMIT;
          end else if (anc.node < col) begin
            node  <= anc.node;
            state <= etb_pkg::ST_READ;
          end else begin
            state <= etb_pkg::ST_IDLE;
          end
        end
        etb_pkg::ST_EMIT: begin
          // wait for the output register to drain
          if (out_free) begin
            out_child  <= node;
            out_parent <= col;
            state      <= etb_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= etb_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
